>>> rtl/core/boxcar_moving_average_defines.svh
// ----------------------------------------------------------------------------
// Boxcar moving average: assertion macros
// Shared macros for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef BOXCAR_MOVING_AVERAGE_DEFINES_SVH
`define BOXCAR_MOVING_AVERAGE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BMA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define BMA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

>>> rtl/core/bma_pkg.sv
// ----------------------------------------------------------------------------
// Boxcar moving average package
// Sizes, the controller command bundle and the datapath status bundle.
// ----------------------------------------------------------------------------
package bma_pkg;

  localparam int MAX_WINDOW  = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int ADDR_W      = $clog2(MAX_WINDOW);
  localparam int LEN_W       = 7;
  // Wide enough to hold MAX_WINDOW itself.
  localparam int DIV_W       = ADDR_W + 1;
  localparam int SUM_W       = SAMPLE_BITS + ADDR_W + 1;
  localparam int CNT_W       = $clog2(SUM_W);

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(MAX_WINDOW);

  typedef struct packed {
    logic capture;
    logic rd_en;
    logic update;
    logic div_start;
    logic div_step;
    logic fill_write;
    logic out_load;
  } bma_cmd_t;

  typedef struct packed {
    logic fill_last;
    logic div_last;
  } bma_status_t;

endpackage

>>> rtl/core/boxcar_moving_average.sv
// ----------------------------------------------------------------------------
// Boxcar moving average
// Mean of the last N signed samples held in a ring, N set by a register.
// ----------------------------------------------------------------------------
// Input stream: s_axis_tdata carries a 16-bit signed value, s_axis_tuser the
// opcode. Opcode 0 pushes the value as a sample and produces one result on
// the output stream: the window sum divided by the window length, truncated
// toward zero. Opcode 1 fills the whole window with the value, rewinds the
// write position and produces no result.
// The window length is written through cfg_wr_en/cfg_wr_data; the user must
// write it only while idle, as the block does not enforce this, and a clear
// request should follow a change of length. A sample request passes through
// a ring read, the running-sum update, the divider load and 23 steps of the
// bit-serial divider before its result is valid. A clear request writes one
// window entry per cycle. One request is in work at a time; the block takes
// the next request while a result still waits in the output register, and a
// finished result waits there for as long as the receiver stalls.
// Reset clears the ring, the position and the sum, and sets the length to 64.
// ----------------------------------------------------------------------------
`include "boxcar_moving_average_defines.svh"

module boxcar_moving_average (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] value
  input  logic        s_axis_tuser,   // [0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [15:0] mean
);
  import bma_pkg::*;

  bma_cmd_t    cmd;
  bma_status_t status;

  bma_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_clear  (s_axis_tuser),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  bma_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_value    (s_axis_tdata),
    .cmd         (cmd),
    .status      (status),
    .mean        (m_axis_tdata)
  );

  // The controller never issues two datapath commands at once.
  `BMA_ASSERT_NOW(a_cmd_exclusive, clk, rst, 1'b1, $onehot0(cmd))
  // A ring read is always followed by the sum update that consumes it.
  `BMA_ASSERT_NEXT(a_read_then_update, clk, rst, cmd.rd_en, cmd.update)
  // The divider always steps in the cycle after it is loaded.
  `BMA_ASSERT_NEXT(a_start_then_step, clk, rst, cmd.div_start, cmd.div_step)
  // A result is never loaded over one the receiver has not taken.
  `BMA_ASSERT_NOW(a_no_overwrite, clk, rst, cmd.out_load, !m_axis_tvalid || m_axis_tready)

endmodule

>>> rtl/core/bma_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module bma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/bma_ctrl.sv
// ----------------------------------------------------------------------------
// Boxcar moving average controller
// Sequences one request at a time and owns the stream handshakes.
// ----------------------------------------------------------------------------
module bma_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_clear,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  bma_pkg::bma_status_t status,
  output bma_pkg::bma_cmd_t    cmd
);
  import bma_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;
  localparam logic [2:0] S_UPDATE = 3'd2;
  localparam logic [2:0] S_DSTART = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;
  localparam logic [2:0] S_FILL   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  // The result register may be refilled in the cycle its current result is taken.
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = in_clear ? S_FILL : S_READ;
        end
      end
      S_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_DSTART;
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_FILL: begin
        cmd.fill_write = 1'b1;
        if (status.fill_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/core/bma_datapath.sv
// ----------------------------------------------------------------------------
// Boxcar moving average datapath
// Sample ring, running sum, serial divider and result register.
// ----------------------------------------------------------------------------
module bma_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [bma_pkg::LEN_W-1:0]       cfg_wr_data,
  input  logic [bma_pkg::SAMPLE_BITS-1:0] in_value,
  input  bma_pkg::bma_cmd_t               cmd,
  output bma_pkg::bma_status_t            status,
  output logic [bma_pkg::SAMPLE_BITS-1:0] mean
);
  import bma_pkg::*;

  localparam logic [SUM_W-1:0] POS_LIMIT = SUM_W'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic [SUM_W-1:0] NEG_LIMIT = SUM_W'(1 << (SAMPLE_BITS - 1));
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic [LEN_W-1:0]         win_len;
  logic [DIV_W-1:0]         eff_len;
  logic [SAMPLE_BITS-1:0]   value_r;
  logic [ADDR_W-1:0]        wpos;
  logic [ADDR_W-1:0]        pos_eff;
  logic [DIV_W-1:0]         pos_inc;
  logic [ADDR_W-1:0]        fill_idx;
  logic [MAX_WINDOW-1:0]    valid;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  sum_next;
  logic [SAMPLE_BITS-1:0]   ram_rdata;
  logic [SAMPLE_BITS-1:0]   old_val;
  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_waddr;
  logic signed [SAMPLE_BITS+LEN_W:0] fill_prod;
  logic [SUM_W-1:0]         quo;
  logic [DIV_W-1:0]         rem;
  logic                     neg;
  logic [CNT_W-1:0]         cnt;
  logic [DIV_W:0]           trial;
  logic                     trial_ge;
  logic [SAMPLE_BITS-1:0]   mean_next;

  // A length of zero acts as one, anything above the ring size as the ring size.
  always_comb begin
    if (win_len == '0) begin
      eff_len = DIV_W'(1);
    end else if (win_len > LEN_W'(MAX_WINDOW)) begin
      eff_len = DIV_W'(MAX_WINDOW);
    end else begin
      eff_len = DIV_W'(win_len);
    end
  end

  // After the length shrinks without a clear, writing restarts at entry zero.
  assign pos_eff = (DIV_W'(wpos) >= eff_len) ? '0 : wpos;
  assign pos_inc = DIV_W'(pos_eff) + DIV_W'(1);

  assign ram_we    = cmd.update | cmd.fill_write;
  assign ram_waddr = cmd.update ? pos_eff : fill_idx;

  bma_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (value_r),
    .re    (cmd.rd_en),
    .raddr (pos_eff),
    .rdata (ram_rdata)
  );

  // Entries never written since reset read as zero.
  assign old_val  = valid[pos_eff] ? ram_rdata : '0;
  assign sum_next = sum
                  - {{(SUM_W-SAMPLE_BITS){old_val[SAMPLE_BITS-1]}}, old_val}
                  + {{(SUM_W-SAMPLE_BITS){value_r[SAMPLE_BITS-1]}}, value_r};

  assign fill_prod = $signed({{(LEN_W+1){value_r[SAMPLE_BITS-1]}}, value_r})
                   * $signed({{(SAMPLE_BITS+LEN_W+1-DIV_W){1'b0}}, eff_len});

  assign status.fill_last = (DIV_W'(fill_idx) == eff_len - DIV_W'(1));
  assign status.div_last  = (cnt == CNT_W'(SUM_W - 1));

  // Restoring division of the magnitude, one quotient bit per cycle.
  assign trial    = {rem, quo[SUM_W-1]};
  assign trial_ge = (trial >= {1'b0, eff_len});

  always_comb begin
    if (!neg) begin
      mean_next = (quo > POS_LIMIT) ? SAMPLE_MAX : quo[SAMPLE_BITS-1:0];
    end else begin
      mean_next = (quo > NEG_LIMIT) ? SAMPLE_MIN
                                    : (~quo[SAMPLE_BITS-1:0] + SAMPLE_BITS'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_len <= LEN_RESET;
      wpos    <= '0;
      sum     <= '0;
      valid   <= '0;
    end else begin
      if (cfg_wr_en) begin
        win_len <= cfg_wr_data;
      end
      if (cmd.update) begin
        sum          <= sum_next;
        valid[pos_eff] <= 1'b1;
        wpos         <= (pos_inc >= eff_len) ? '0 : pos_inc[ADDR_W-1:0];
      end
      if (cmd.fill_write) begin
        valid[fill_idx] <= 1'b1;
        if (status.fill_last) begin
          sum  <= fill_prod[SUM_W-1:0];
          wpos <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      value_r  <= in_value;
      fill_idx <= '0;
    end else if (cmd.fill_write) begin
      fill_idx <= fill_idx + ADDR_W'(1);
    end
    if (cmd.div_start) begin
      neg <= sum[SUM_W-1];
      quo <= sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
      rem <= '0;
      cnt <= '0;
    end else if (cmd.div_step) begin
      rem <= trial_ge ? DIV_W'(trial - {1'b0, eff_len}) : trial[DIV_W-1:0];
      quo <= {quo[SUM_W-2:0], trial_ge};
      cnt <= cnt + CNT_W'(1);
    end
    if (cmd.out_load) begin
      mean <= mean_next;
    end
  end

endmodule
